// ===== hdl/wmc_pkg.sv =====
// Shared types, constants and calendar helpers for the watch set-mode controller.
`default_nettype none

package wmc_pkg;

    // Parameter defaults and limits
    localparam int THEME_COUNT_DEF = 4;
    localparam int YEAR_FIRST_DEF  = 2022;
    localparam int YEAR_LAST_DEF   = 2099;
    localparam int THEME_W         = 4;     // holds any theme index up to sixteen themes

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;
    localparam logic [CFG_IDX_W-1:0] CFG_TILT_THRESHOLD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TILT_BUDGET     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THEME_THRESHOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THEME_DELAY     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_PERIOD    = 3'd4;

    // Register reset values
    localparam logic [11:0] TILT_THRESHOLD_RST  = 12'd200;
    localparam logic [13:0] TILT_BUDGET_RST     = 14'd600;
    localparam logic [11:0] THEME_THRESHOLD_RST = 12'd30;
    localparam logic [3:0]  THEME_DELAY_RST     = 4'd4;
    localparam logic [3:0]  BLINK_PERIOD_RST    = 4'd5;

    // Calendar limits and reset date
    localparam logic [11:0] WEEKDAY_LAST = 12'd6;
    localparam logic [11:0] MONTH_LAST   = 12'd12;
    localparam logic [11:0] HOUR_LAST    = 12'd23;
    localparam logic [11:0] MINSEC_LAST  = 12'd59;
    localparam logic [2:0]  POS_LAST     = 3'd6;

    // Field cursor codes
    localparam logic [2:0] POS_WEEKDAY = 3'd0;
    localparam logic [2:0] POS_DAY     = 3'd1;
    localparam logic [2:0] POS_MONTH   = 3'd2;
    localparam logic [2:0] POS_YEAR    = 3'd3;
    localparam logic [2:0] POS_HOUR    = 3'd4;
    localparam logic [2:0] POS_MINUTE  = 3'd5;

    // Mode codes as shown on the result channel
    localparam logic [2:0] MODE_CODE_IDLE   = 3'd0;
    localparam logic [2:0] MODE_CODE_CONFIG = 3'd1;
    localparam logic [2:0] MODE_CODE_EDIT   = 3'd2;
    localparam logic [2:0] MODE_CODE_CHOOSE = 3'd3;
    localparam logic [2:0] MODE_CODE_THEME  = 3'd4;

    typedef enum logic [4:0] {
        M_IDLE   = 5'b00001,
        M_CONFIG = 5'b00010,
        M_EDIT   = 5'b00100,
        M_CHOOSE = 5'b01000,
        M_THEME  = 5'b10000
    } mode_t;

    typedef struct packed {
        logic [11:0] tilt_threshold;
        logic [13:0] tilt_budget;
        logic [11:0] theme_threshold;
        logic [3:0]  theme_delay;
        logic [3:0]  blink_period;
    } cfg_t;

    typedef struct packed {
        logic               press;
        logic               turn_up;
        logic               turn_down;
        logic signed [15:0] tilt_x;
        logic signed [15:0] tilt_y;
    } beat_t;

    typedef struct packed {
        logic [2:0]  weekday;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [11:0] year;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } date_t;

    typedef struct packed {
        logic [2:0] mode;
        logic [2:0] field_pos;
        date_t      date;
        logic [1:0] theme_sel;
        logic       blink_flag;
        logic       time_written;
    } res_t;

    localparam date_t DATE_RST = '{
        weekday: 3'd4, day: 5'd13, month: 4'd10, year: 12'(YEAR_FIRST_DEF),
        hour: 5'd7, minute: 6'd12, second: 6'd0
    };

    function automatic logic [2:0] mode_code(input mode_t m);
        logic [2:0] c;
        begin
            unique case (m)
                M_IDLE:   c = MODE_CODE_IDLE;
                M_CONFIG: c = MODE_CODE_CONFIG;
                M_EDIT:   c = MODE_CODE_EDIT;
                M_CHOOSE: c = MODE_CODE_CHOOSE;
                M_THEME:  c = MODE_CODE_THEME;
                default:  c = MODE_CODE_IDLE;
            endcase
            return c;
        end
    endfunction

    function automatic logic [11:0] wrap_up(input logic [11:0] v, input logic [11:0] lo,
                                            input logic [11:0] hi);
        return (v >= hi || v < lo) ? lo : v + 12'd1;
    endfunction

    function automatic logic [11:0] wrap_down(input logic [11:0] v, input logic [11:0] lo,
                                              input logic [11:0] hi);
        return (v <= lo || v > hi) ? hi : v - 12'd1;
    endfunction

    // February follows year mod 4; out-of-range months count as 31 days
    function automatic logic [4:0] month_days(input logic [3:0] month, input logic [11:0] year);
        logic [4:0] d;
        begin
            unique case (month)
                4'd2:                      d = (year[1:0] == 2'd0) ? 5'd29 : 5'd28;
                4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
                default:                   d = 5'd31;
            endcase
            return d;
        end
    endfunction

endpackage

`default_nettype wire

// ===== hdl/wmc_in_stage.sv =====
// Input register stage: captures one input beat and holds it until the core takes it.
`default_nettype none

module wmc_in_stage (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire wmc_pkg::beat_t s_beat,
    input  wire logic          take,
    output logic               beat_valid,
    output wmc_pkg::beat_t     beat
);

    logic           valid_reg;
    logic           valid_next;
    wmc_pkg::beat_t beat_reg;

    assign s_ready    = !valid_reg || take;
    assign valid_next = (s_valid && s_ready) ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            beat_reg <= s_beat;
        end
    end

    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

endmodule

`default_nettype wire

// ===== hdl/wmc_core.sv =====
// Controller state and the per-tick next-state logic.
`default_nettype none

module wmc_core #(
    parameter int THEME_COUNT = wmc_pkg::THEME_COUNT_DEF,
    parameter int YEAR_FIRST  = wmc_pkg::YEAR_FIRST_DEF,
    parameter int YEAR_LAST   = wmc_pkg::YEAR_LAST_DEF
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire wmc_pkg::cfg_t  cfg,
    input  wire logic           step,
    input  wire wmc_pkg::beat_t beat,
    output wmc_pkg::res_t       res
);

    localparam logic [wmc_pkg::THEME_W:0] THEME_N    = (wmc_pkg::THEME_W + 1)'(THEME_COUNT);
    localparam logic [wmc_pkg::THEME_W-1:0] THEME_MAX = wmc_pkg::THEME_W'(THEME_COUNT - 1);
    localparam logic [11:0] YR_LO = 12'(YEAR_FIRST);
    localparam logic [11:0] YR_HI = 12'(YEAR_LAST);

    // Reset date; the year starts at the first year of the range
    localparam wmc_pkg::date_t DATE_INIT = '{
        weekday: wmc_pkg::DATE_RST.weekday, day: wmc_pkg::DATE_RST.day,
        month: wmc_pkg::DATE_RST.month, year: YR_LO, hour: wmc_pkg::DATE_RST.hour,
        minute: wmc_pkg::DATE_RST.minute, second: wmc_pkg::DATE_RST.second
    };

    wmc_pkg::mode_t               mode_reg, mode_next;
    logic [2:0]                   pos_reg, pos_next;
    wmc_pkg::date_t               date_reg, date_next, date_up;
    logic [13:0]                  tilt_left_reg, tilt_left_next;
    logic                         pend_up_reg, pend_up_next;
    logic                         pend_dn_reg, pend_dn_next;
    logic signed [15:0]           ref_y_reg, ref_y_next;
    logic [wmc_pkg::THEME_W-1:0]  theme_reg, theme_next;
    logic [3:0]                   delay_reg, delay_next;
    logic [3:0]                   blink_cnt_reg, blink_cnt_next;
    logic                         blink_reg, blink_next;

    logic               pu, pd;
    logic [16:0]        abs_x;
    logic signed [16:0] sx;
    logic signed [17:0] left_sub;
    logic               drain, fire;
    logic signed [16:0] dy;
    logic [16:0]        abs_dy;
    logic [3:0]         blink_inc;
    logic [wmc_pkg::THEME_W:0] theme_inc;
    logic               written;

    // One step of the selected field, with wrap
    function automatic wmc_pkg::date_t edit(input wmc_pkg::date_t d, input logic [2:0] pos,
                                            input logic up);
        wmc_pkg::date_t r;
        logic [4:0]     ml;
        begin
            r  = d;
            ml = wmc_pkg::month_days(d.month, d.year);
            unique case (pos)
                wmc_pkg::POS_WEEKDAY: r.weekday = 3'(up ?
                    wmc_pkg::wrap_up({9'd0, d.weekday}, 12'd0, wmc_pkg::WEEKDAY_LAST) :
                    wmc_pkg::wrap_down({9'd0, d.weekday}, 12'd0, wmc_pkg::WEEKDAY_LAST));
                wmc_pkg::POS_DAY: begin
                    if (up) r.day = (d.day >= ml) ? 5'd1 : d.day + 5'd1;
                    else    r.day = (d.day <= 5'd1) ? ml : d.day - 5'd1;
                end
                wmc_pkg::POS_MONTH: r.month = 4'(up ?
                    wmc_pkg::wrap_up({8'd0, d.month}, 12'd1, wmc_pkg::MONTH_LAST) :
                    wmc_pkg::wrap_down({8'd0, d.month}, 12'd1, wmc_pkg::MONTH_LAST));
                wmc_pkg::POS_YEAR: r.year = up ? wmc_pkg::wrap_up(d.year, YR_LO, YR_HI) :
                                                 wmc_pkg::wrap_down(d.year, YR_LO, YR_HI);
                wmc_pkg::POS_HOUR: r.hour = 5'(up ?
                    wmc_pkg::wrap_up({7'd0, d.hour}, 12'd0, wmc_pkg::HOUR_LAST) :
                    wmc_pkg::wrap_down({7'd0, d.hour}, 12'd0, wmc_pkg::HOUR_LAST));
                wmc_pkg::POS_MINUTE: r.minute = 6'(up ?
                    wmc_pkg::wrap_up({6'd0, d.minute}, 12'd0, wmc_pkg::MINSEC_LAST) :
                    wmc_pkg::wrap_down({6'd0, d.minute}, 12'd0, wmc_pkg::MINSEC_LAST));
                default: r.second = 6'(up ?
                    wmc_pkg::wrap_up({6'd0, d.second}, 12'd0, wmc_pkg::MINSEC_LAST) :
                    wmc_pkg::wrap_down({6'd0, d.second}, 12'd0, wmc_pkg::MINSEC_LAST));
            endcase
            return r;
        end
    endfunction

    always_comb begin
        mode_next      = mode_reg;
        pos_next       = pos_reg;
        date_next      = date_reg;
        date_up        = date_reg;
        tilt_left_next = tilt_left_reg;
        ref_y_next     = ref_y_reg;
        theme_next     = theme_reg;
        delay_next     = delay_reg;
        blink_cnt_next = blink_cnt_reg;
        blink_next     = blink_reg;
        written        = 1'b0;

        pu = pend_up_reg || beat.turn_up;
        pd = pend_dn_reg || beat.turn_down;

        // Press steps the mode and latches the Y reference
        if (beat.press) begin
            ref_y_next = beat.tilt_y;
            unique case (mode_reg)
                wmc_pkg::M_IDLE:   mode_next = wmc_pkg::M_CONFIG;
                wmc_pkg::M_CONFIG: mode_next = wmc_pkg::M_CHOOSE;
                wmc_pkg::M_CHOOSE: mode_next = wmc_pkg::M_EDIT;
                wmc_pkg::M_EDIT:   mode_next = wmc_pkg::M_THEME;
                default:           mode_next = wmc_pkg::M_IDLE;
            endcase
        end

        // X tilt drains the budget in the choose and edit modes
        sx       = {beat.tilt_x[15], beat.tilt_x};
        abs_x    = sx[16] ? 17'(-sx) : 17'(sx);
        drain    = (mode_next == wmc_pkg::M_EDIT || mode_next == wmc_pkg::M_CHOOSE) &&
                   (abs_x > {5'd0, cfg.tilt_threshold});
        left_sub = $signed({4'd0, tilt_left_reg}) - $signed({1'b0, abs_x});
        fire     = drain && (left_sub <= 18'sd0);
        if (drain) begin
            tilt_left_next = fire ? cfg.tilt_budget : left_sub[13:0];
        end
        if (fire) begin
            if (!sx[16]) pu = 1'b1;
            else         pd = 1'b1;
        end

        // Cursor moves; up wins and down stays pending
        if (mode_next == wmc_pkg::M_CHOOSE) begin
            if (pu) begin
                pos_next = (pos_reg >= wmc_pkg::POS_LAST) ? 3'd0 : pos_reg + 3'd1;
                pu       = 1'b0;
            end else if (pd) begin
                pos_next = (pos_reg == 3'd0 || pos_reg > wmc_pkg::POS_LAST) ?
                           wmc_pkg::POS_LAST : pos_reg - 3'd1;
                pd       = 1'b0;
            end
        end

        // Field edit: up first, then down on the result
        if (mode_next == wmc_pkg::M_EDIT) begin
            date_up   = pu ? edit(date_reg, pos_reg, 1'b1) : date_reg;
            date_next = pd ? edit(date_up, pos_reg, 1'b0) : date_up;
            written   = pu || pd;
            pu        = 1'b0;
            pd        = 1'b0;
        end

        // Theme mode: blink and tilt-stepped theme
        blink_inc = blink_cnt_reg + 4'd1;
        dy        = $signed({beat.tilt_y[15], beat.tilt_y}) -
                    $signed({ref_y_next[15], ref_y_next});
        abs_dy    = dy[16] ? 17'(-dy) : 17'(dy);
        theme_inc = {1'b0, theme_reg} + 1'b1;
        if (mode_next == wmc_pkg::M_THEME) begin
            blink_cnt_next = blink_inc;
            if (blink_inc == cfg.blink_period) begin
                blink_next     = !blink_reg;
                blink_cnt_next = 4'd0;
            end
            if (abs_dy > {5'd0, cfg.theme_threshold}) begin
                if (delay_reg == 4'd0) begin
                    if (!dy[16]) begin
                        theme_next = (theme_inc >= THEME_N) ? '0 : theme_inc[wmc_pkg::THEME_W-1:0];
                    end else begin
                        theme_next = (theme_reg == '0 || {1'b0, theme_reg} >= THEME_N) ?
                                     THEME_MAX : theme_reg - 1'b1;
                    end
                    delay_next = cfg.theme_delay;
                end else begin
                    delay_next = delay_reg - 4'd1;
                end
            end
        end

        pend_up_next = pu;
        pend_dn_next = pd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= wmc_pkg::M_IDLE;
            pos_reg       <= 3'd0;
            date_reg      <= DATE_INIT;
            tilt_left_reg <= wmc_pkg::TILT_BUDGET_RST;
            pend_up_reg   <= 1'b0;
            pend_dn_reg   <= 1'b0;
            ref_y_reg     <= '0;
            theme_reg     <= '0;
            delay_reg     <= wmc_pkg::THEME_DELAY_RST;
            blink_cnt_reg <= 4'd0;
            blink_reg     <= 1'b0;
        end else if (step) begin
            mode_reg      <= mode_next;
            pos_reg       <= pos_next;
            date_reg      <= date_next;
            tilt_left_reg <= tilt_left_next;
            pend_up_reg   <= pend_up_next;
            pend_dn_reg   <= pend_dn_next;
            ref_y_reg     <= ref_y_next;
            theme_reg     <= theme_next;
            delay_reg     <= delay_next;
            blink_cnt_reg <= blink_cnt_next;
            blink_reg     <= blink_next;
        end
    end

    always_comb begin
        res.mode         = wmc_pkg::mode_code(mode_next);
        res.field_pos    = pos_next;
        res.date         = date_next;
        res.theme_sel    = theme_next[1:0];
        res.blink_flag   = blink_next;
        res.time_written = written;
    end

endmodule

`default_nettype wire

// ===== hdl/watch_set_mode_controller_core.sv =====
// Top level of the watch set-mode controller: config registers, input stage, core, result register.
//
//  channel   dir  handshake            payload
//  s_*       in   s_valid / s_ready    press, turn_up, turn_down, tilt_x, tilt_y
//  m_*       out  m_valid / m_ready    mode .. time_written, one result per tick
//  cfg_*     in   cfg_wen              cfg_index, cfg_wdata (no read-back)
//
// Beats pass the input register, then the result register; one beat per cycle with m_ready high.
// The rate is set by the combinational tick logic in wmc_core, which closes state in one step.
// Reset is synchronous, active low; config returns to its defaults, no clearing pass.
// A stalled result holds the core; the input register still takes one beat meanwhile.
`default_nettype none

module watch_set_mode_controller_core #(
    parameter int THEME_COUNT = wmc_pkg::THEME_COUNT_DEF,
    parameter int YEAR_FIRST  = wmc_pkg::YEAR_FIRST_DEF,
    parameter int YEAR_LAST   = wmc_pkg::YEAR_LAST_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // configuration writes
    input  wire logic                            cfg_wen,
    input  wire logic [wmc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [wmc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // input beats
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic                            s_press,
    input  wire logic                            s_turn_up,
    input  wire logic                            s_turn_down,
    input  wire logic signed [15:0]              s_tilt_x,
    input  wire logic signed [15:0]              s_tilt_y,
    // result beats
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [2:0]                           m_mode,
    output logic [2:0]                           m_field_pos,
    output logic [2:0]                           m_weekday,
    output logic [4:0]                           m_day_of_month,
    output logic [3:0]                           m_month_num,
    output logic [11:0]                          m_year_num,
    output logic [4:0]                           m_hour_num,
    output logic [5:0]                           m_minute_num,
    output logic [5:0]                           m_second_num,
    output logic [1:0]                           m_theme_sel,
    output logic                                 m_blink_flag,
    output logic                                 m_time_written
);

    wmc_pkg::cfg_t  cfg_reg;
    wmc_pkg::beat_t s_beat, beat;
    wmc_pkg::res_t  res, res_reg;
    logic           beat_valid;
    logic           step;
    logic           m_valid_reg, m_valid_next;

    // Config registers; out-of-list indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.tilt_threshold  <= wmc_pkg::TILT_THRESHOLD_RST;
            cfg_reg.tilt_budget     <= wmc_pkg::TILT_BUDGET_RST;
            cfg_reg.theme_threshold <= wmc_pkg::THEME_THRESHOLD_RST;
            cfg_reg.theme_delay     <= wmc_pkg::THEME_DELAY_RST;
            cfg_reg.blink_period    <= wmc_pkg::BLINK_PERIOD_RST;
        end else if (cfg_wen) begin
            unique case (cfg_index)
                wmc_pkg::CFG_TILT_THRESHOLD:  cfg_reg.tilt_threshold  <= cfg_wdata[11:0];
                wmc_pkg::CFG_TILT_BUDGET:     cfg_reg.tilt_budget     <= cfg_wdata;
                wmc_pkg::CFG_THEME_THRESHOLD: cfg_reg.theme_threshold <= cfg_wdata[11:0];
                wmc_pkg::CFG_THEME_DELAY:     cfg_reg.theme_delay     <= cfg_wdata[3:0];
                wmc_pkg::CFG_BLINK_PERIOD:    cfg_reg.blink_period    <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    assign s_beat = '{press: s_press, turn_up: s_turn_up, turn_down: s_turn_down,
                      tilt_x: s_tilt_x, tilt_y: s_tilt_y};

    // Core advances when a beat is held and the result slot is free or draining
    assign step = beat_valid && (!m_valid_reg || m_ready);

    wmc_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_beat     (s_beat),
        .take       (step),
        .beat_valid (beat_valid),
        .beat       (beat)
    );

    wmc_core #(
        .THEME_COUNT (THEME_COUNT),
        .YEAR_FIRST  (YEAR_FIRST),
        .YEAR_LAST   (YEAR_LAST)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .step    (step),
        .beat    (beat),
        .res     (res)
    );

    // Result register
    assign m_valid_next = step ? 1'b1 : ((m_valid_reg && m_ready) ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            res_reg <= res;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_mode         = res_reg.mode;
    assign m_field_pos    = res_reg.field_pos;
    assign m_weekday      = res_reg.date.weekday;
    assign m_day_of_month = res_reg.date.day;
    assign m_month_num    = res_reg.date.month;
    assign m_year_num     = res_reg.date.year;
    assign m_hour_num     = res_reg.date.hour;
    assign m_minute_num   = res_reg.date.minute;
    assign m_second_num   = res_reg.date.second;
    assign m_theme_sel    = res_reg.theme_sel;
    assign m_blink_flag   = res_reg.blink_flag;
    assign m_time_written = res_reg.time_written;

endmodule

`default_nettype wire
